@@ rtl/core/zone_vehicle_presence_detector_defines.svh @@
// ----------------------------------------------------------------------------
// Zone vehicle presence detector assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ZONE_VEHICLE_PRESENCE_DETECTOR_DEFINES_SVH
`define ZONE_VEHICLE_PRESENCE_DETECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZVPD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zvpd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ZVPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zvpd assertion failed");

`endif

@@ rtl/core/zvpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Zone vehicle presence detector package
// Types, register codes, reset values and constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package zvpd_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_PIXELS_DEFAULT  = 16384;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Shadow band shape.
    localparam int SHADOW_UPPER_CAP  = 128;
    localparam int SHADOW_DARK_LEVEL = 20;
    localparam int SHADOW_BAND       = 60;

    localparam int MS_PER_SECOND = 1000;

    // Width of the configuration data port and of the wide registers.
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_BEAM_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_POINTS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_POINTS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_POINTS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_MAX_WRONG = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_MAX_WRONG   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REENTER_INTERVAL = 3'd7;

    localparam logic [7:0]       RST_DIFF_THRESHOLD   = 8'd20;
    localparam logic [7:0]       RST_LIGHT_BEAM_LEVEL = 8'd230;
    localparam logic [CFG_W-1:0] RST_ENTER_POINTS     = 15'd100;
    localparam logic [CFG_W-1:0] RST_EXIT_POINTS      = 15'd50;
    localparam logic [CFG_W-1:0] RST_CONFIRM_POINTS   = 15'd50;
    localparam logic [CFG_W-1:0] RST_SHADOW_MAX_WRONG = 15'd20;
    localparam logic [CFG_W-1:0] RST_BEAM_MAX_WRONG   = 15'd20;
    localparam logic [9:0]       RST_REENTER_INTERVAL = 10'd200;

    typedef struct packed {
        logic [7:0]       diff_threshold;
        logic [7:0]       light_beam_level;
        logic [CFG_W-1:0] enter_points;
        logic [CFG_W-1:0] exit_points;
        logic [CFG_W-1:0] confirm_points;
        logic [CFG_W-1:0] shadow_max_wrong;
        logic [CFG_W-1:0] beam_max_wrong;
        logic [9:0]       reenter_interval_ms;
    } cfg_t;

    // One classified pixel as it travels from the front to the back.
    typedef struct packed {
        logic        changed;
        logic        beam;
        logic        shadow;
        logic        last;
        logic [31:0] time_ms;
    } pixel_class_t;

    typedef enum logic [1:0] {
        ZS_ROAD   = 2'd0,
        ZS_CAR    = 2'd1,
        ZS_SHADOW = 2'd2,
        ZS_BEAM   = 2'd3
    } zone_state_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_LEAVE = 2'd2
    } event_t;

endpackage

`default_nettype wire

@@ rtl/core/zone_vehicle_presence_detector.sv @@
// ----------------------------------------------------------------------------
// Zone vehicle presence detector
// Counts changed pixels of a zone per frame and reports car enter and exit.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock while in_stall is low. It gives
// one result per last pixel, which is queued, popped in its turn and sets the
// out_valid register. The front classifies each accepted pixel and writes it
// into a queue of QUEUE_DEPTH entries. The back drains one entry per clock,
// unless a held result blocks a frame end, into the frame counters and, at a
// frame end, runs the zone state machine into a result register. in_stall
// rises only once a result has been held by out_stall and the queue has
// filled behind it. Configuration registers are written through cfg_we,
// cfg_index and cfg_data, and take effect from the cycle after the write.
// ----------------------------------------------------------------------------
`default_nettype none

module zone_vehicle_presence_detector
#(
    parameter int MAX_PIXELS  = zvpd_pkg::MAX_PIXELS_DEFAULT,
    parameter int QUEUE_DEPTH = zvpd_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [zvpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [zvpd_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      frame_pixel,
    input  wire logic [7:0]                      background_pixel,
    input  wire logic                            in_zone,
    input  wire logic                            last_pixel,
    input  wire logic [31:0]                     time_ms,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           event_res,
    output logic [1:0]                           zone_state,
    output logic [zvpd_pkg::CFG_W-1:0]           changed_count,
    output logic [zvpd_pkg::CFG_W-1:0]           shadow_count,
    output logic [zvpd_pkg::CFG_W-1:0]           beam_count
);

    zvpd_pkg::cfg_t         cfg_reg;
    zvpd_pkg::cfg_t         cfg_next;
    zvpd_pkg::pixel_class_t push_entry;
    zvpd_pkg::pixel_class_t head;
    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                zvpd_pkg::CFG_DIFF_THRESHOLD:   cfg_next.diff_threshold   = cfg_data[7:0];
                zvpd_pkg::CFG_LIGHT_BEAM_LEVEL: cfg_next.light_beam_level = cfg_data[7:0];
                zvpd_pkg::CFG_ENTER_POINTS:     cfg_next.enter_points     = cfg_data;
                zvpd_pkg::CFG_EXIT_POINTS:      cfg_next.exit_points      = cfg_data;
                zvpd_pkg::CFG_CONFIRM_POINTS:   cfg_next.confirm_points   = cfg_data;
                zvpd_pkg::CFG_SHADOW_MAX_WRONG: cfg_next.shadow_max_wrong = cfg_data;
                zvpd_pkg::CFG_BEAM_MAX_WRONG:   cfg_next.beam_max_wrong   = cfg_data;
                zvpd_pkg::CFG_REENTER_INTERVAL: cfg_next.reenter_interval_ms = cfg_data[9:0];
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diff_threshold      <= zvpd_pkg::RST_DIFF_THRESHOLD;
            cfg_reg.light_beam_level    <= zvpd_pkg::RST_LIGHT_BEAM_LEVEL;
            cfg_reg.enter_points        <= zvpd_pkg::RST_ENTER_POINTS;
            cfg_reg.exit_points         <= zvpd_pkg::RST_EXIT_POINTS;
            cfg_reg.confirm_points      <= zvpd_pkg::RST_CONFIRM_POINTS;
            cfg_reg.shadow_max_wrong    <= zvpd_pkg::RST_SHADOW_MAX_WRONG;
            cfg_reg.beam_max_wrong      <= zvpd_pkg::RST_BEAM_MAX_WRONG;
            cfg_reg.reenter_interval_ms <= zvpd_pkg::RST_REENTER_INTERVAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    zvpd_front u_front
    (
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .frame_pixel      (frame_pixel),
        .background_pixel (background_pixel),
        .in_zone          (in_zone),
        .last_pixel       (last_pixel),
        .time_ms          (time_ms),
        .cfg              (cfg_reg),
        .queue_full       (queue_full),
        .push             (push),
        .push_entry       (push_entry)
    );

    zvpd_queue
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head       (head)
    );

    zvpd_back
    #(
        .MAX_PIXELS (MAX_PIXELS)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .queue_empty   (queue_empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .zone_state    (zone_state),
        .changed_count (changed_count),
        .shadow_count  (shadow_count),
        .beam_count    (beam_count)
    );

endmodule

`default_nettype wire

@@ rtl/core/zvpd_front.sv @@
// ----------------------------------------------------------------------------
// Zone vehicle presence detector front end
// Accepts pixel requests and classifies each as changed, light beam or shadow.
// ----------------------------------------------------------------------------
`default_nettype none

module zvpd_front
(
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            frame_pixel,
    input  wire logic [7:0]            background_pixel,
    input  wire logic                  in_zone,
    input  wire logic                  last_pixel,
    input  wire logic [31:0]           time_ms,
    input  wire zvpd_pkg::cfg_t        cfg,
    input  wire logic                  queue_full,
    output logic                       push,
    output zvpd_pkg::pixel_class_t     push_entry
);

    localparam logic [9:0] UPPER_CAP   = 10'(zvpd_pkg::SHADOW_UPPER_CAP);
    localparam logic [9:0] DARK_LEVEL  = 10'(zvpd_pkg::SHADOW_DARK_LEVEL);
    localparam logic [9:0] BAND        = 10'(zvpd_pkg::SHADOW_BAND);
    localparam logic [9:0] BAND_SWITCH = 10'(zvpd_pkg::SHADOW_DARK_LEVEL
                                             + zvpd_pkg::SHADOW_BAND);

    logic       brighter;
    logic [7:0] abs_diff;
    logic       changed;
    logic [9:0] upper_raw;
    logic [9:0] upper;
    logic [9:0] lower;
    logic [9:0] frame_w;
    logic       in_band;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        brighter  = frame_pixel >= background_pixel;
        abs_diff  = brighter ? frame_pixel - background_pixel
                             : background_pixel - frame_pixel;
        changed   = in_zone && (abs_diff > cfg.diff_threshold);

        // Shadow band sits below the background, capped and with a dark floor.
        upper_raw = {2'b00, background_pixel} - {2'b00, cfg.diff_threshold};
        upper     = (upper_raw > UPPER_CAP) ? UPPER_CAP : upper_raw;
        lower     = (upper > BAND_SWITCH) ? upper - BAND : DARK_LEVEL;
        frame_w   = {2'b00, frame_pixel};
        in_band   = (background_pixel > cfg.diff_threshold)
                    && (frame_w > lower) && (frame_w < upper);

        push_entry.changed = changed;
        push_entry.beam    = changed && brighter && (frame_pixel >= cfg.light_beam_level);
        push_entry.shadow  = changed && !brighter && in_band;
        push_entry.last    = last_pixel;
        push_entry.time_ms = time_ms;
    end

endmodule

`default_nettype wire

@@ rtl/core/zvpd_queue.sv @@
// ----------------------------------------------------------------------------
// Zone vehicle presence detector queue
// Short first-in first-out buffer of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zone_vehicle_presence_detector_defines.svh"

module zvpd_queue
#(
    parameter int QUEUE_DEPTH = zvpd_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire zvpd_pkg::pixel_class_t push_entry,
    input  wire logic                   pop,
    output logic                        full,
    output logic                        empty,
    output zvpd_pkg::pixel_class_t      head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    zvpd_pkg::pixel_class_t entry_reg [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = count_reg == DEPTH_CNT;
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `ZVPD_ASSERT_SAME(a_no_push_when_full, full, !push)
    `ZVPD_ASSERT_SAME(a_no_pop_when_empty, empty, !pop)

endmodule

`default_nettype wire

@@ rtl/core/zvpd_back.sv @@
// ----------------------------------------------------------------------------
// Zone vehicle presence detector back end
// Accumulates frame totals, runs the zone state machine and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zone_vehicle_presence_detector_defines.svh"

module zvpd_back
#(
    parameter int MAX_PIXELS = zvpd_pkg::MAX_PIXELS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire zvpd_pkg::cfg_t         cfg,
    input  wire logic                   queue_empty,
    input  wire zvpd_pkg::pixel_class_t head,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  event_res,
    output logic [1:0]                  zone_state,
    output logic [zvpd_pkg::CFG_W-1:0]  changed_count,
    output logic [zvpd_pkg::CFG_W-1:0]  shadow_count,
    output logic [zvpd_pkg::CFG_W-1:0]  beam_count
);

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int CMP_W = (CNT_W > zvpd_pkg::CFG_W) ? CNT_W : zvpd_pkg::CFG_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);
    localparam logic [9:0] SECOND_MS = 10'(zvpd_pkg::MS_PER_SECOND);

    // The changed total saturates on its own; it equals the saturated sum
    // of the brighter and darker totals, so those need no registers.
    logic [CNT_W-1:0] total_cnt_reg;
    logic [CNT_W-1:0] total_cnt_next;
    logic [CNT_W-1:0] shadow_cnt_reg;
    logic [CNT_W-1:0] shadow_cnt_next;
    logic [CNT_W-1:0] beam_cnt_reg;
    logic [CNT_W-1:0] beam_cnt_next;
    logic [31:0]      exit_stamp_reg;
    logic [31:0]      exit_stamp_next;

    zvpd_pkg::zone_state_t state_reg;
    zvpd_pkg::zone_state_t state_next;
    zvpd_pkg::event_t      event_reg;
    zvpd_pkg::event_t      event_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CMP_W-1:0] total_res_reg;
    logic [CMP_W-1:0] shadow_res_reg;
    logic [CMP_W-1:0] beam_res_reg;

    logic             out_free;
    logic             frame_end;
    logic [CNT_W-1:0] total_upd;
    logic [CNT_W-1:0] shadow_upd;
    logic [CNT_W-1:0] beam_upd;
    logic [CMP_W-1:0] total_w;
    logic [CMP_W-1:0] wrong_shadow;
    logic [CMP_W-1:0] wrong_beam;
    logic             shadow_seen;
    logic             beam_seen;
    logic             below_exit;
    logic [31:0]      since_exit;
    logic             hold_ok;

    // A frame end may only leave the queue when the result register is free.
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = !queue_empty && (!head.last || out_free);
    assign frame_end = pop && head.last;

    always_comb
    begin
        total_upd  = total_cnt_reg;
        shadow_upd = shadow_cnt_reg;
        beam_upd   = beam_cnt_reg;
        if (head.changed && (total_cnt_reg != MAX_CNT))
        begin
            total_upd = total_cnt_reg + 1'b1;
        end
        if (head.shadow && (shadow_cnt_reg != MAX_CNT))
        begin
            shadow_upd = shadow_cnt_reg + 1'b1;
        end
        if (head.beam && (beam_cnt_reg != MAX_CNT))
        begin
            beam_upd = beam_cnt_reg + 1'b1;
        end

        total_w      = CMP_W'(total_upd);
        wrong_shadow = total_w - CMP_W'(shadow_upd);
        wrong_beam   = total_w - CMP_W'(beam_upd);
        shadow_seen  = (shadow_upd != '0)
                       && (wrong_shadow <= CMP_W'(cfg.shadow_max_wrong));
        beam_seen    = (beam_upd != '0)
                       && (wrong_beam <= CMP_W'(cfg.beam_max_wrong));
        below_exit   = total_w < CMP_W'(cfg.exit_points);

        // Wrapping time since the last exit.
        since_exit = head.time_ms - exit_stamp_reg;
        hold_ok    = (since_exit[31:10] != '0) || (since_exit[9:0] >= SECOND_MS)
                     || (since_exit[9:0] > cfg.reenter_interval_ms);
    end

    always_comb
    begin
        state_next      = state_reg;
        event_next      = zvpd_pkg::EV_NONE;
        exit_stamp_next = exit_stamp_reg;

        case (state_reg)
            zvpd_pkg::ZS_ROAD:
            begin
                if (total_w > CMP_W'(cfg.enter_points))
                begin
                    if (shadow_seen)
                    begin
                        state_next = zvpd_pkg::ZS_SHADOW;
                    end
                    else if (beam_seen)
                    begin
                        state_next = zvpd_pkg::ZS_BEAM;
                    end
                    else if (hold_ok)
                    begin
                        state_next = zvpd_pkg::ZS_CAR;
                        event_next = zvpd_pkg::EV_ENTER;
                    end
                end
            end
            zvpd_pkg::ZS_CAR:
            begin
                if (shadow_seen)
                begin
                    state_next = zvpd_pkg::ZS_SHADOW;
                    event_next = zvpd_pkg::EV_LEAVE;
                end
                else if (beam_seen)
                begin
                    state_next = zvpd_pkg::ZS_BEAM;
                    event_next = zvpd_pkg::EV_LEAVE;
                end
                else if (below_exit)
                begin
                    state_next = zvpd_pkg::ZS_ROAD;
                    event_next = zvpd_pkg::EV_LEAVE;
                end
                if (event_next == zvpd_pkg::EV_LEAVE)
                begin
                    exit_stamp_next = head.time_ms;
                end
            end
            zvpd_pkg::ZS_SHADOW:
            begin
                if (wrong_shadow > CMP_W'(cfg.confirm_points))
                begin
                    if (hold_ok)
                    begin
                        state_next = zvpd_pkg::ZS_CAR;
                        event_next = zvpd_pkg::EV_ENTER;
                    end
                end
                else if (below_exit && (wrong_shadow < CMP_W'(cfg.shadow_max_wrong)))
                begin
                    state_next = zvpd_pkg::ZS_ROAD;
                end
            end
            zvpd_pkg::ZS_BEAM:
            begin
                if (wrong_beam > CMP_W'(cfg.confirm_points))
                begin
                    if (hold_ok)
                    begin
                        state_next = zvpd_pkg::ZS_CAR;
                        event_next = zvpd_pkg::EV_ENTER;
                    end
                end
                else if (below_exit && (wrong_beam < CMP_W'(cfg.beam_max_wrong)))
                begin
                    state_next = zvpd_pkg::ZS_ROAD;
                end
            end
            default:
            begin
                state_next = zvpd_pkg::ZS_ROAD;
            end
        endcase

        // Counters keep running on ordinary pixels and clear at a frame end.
        total_cnt_next  = total_cnt_reg;
        shadow_cnt_next = shadow_cnt_reg;
        beam_cnt_next   = beam_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (pop)
        begin
            if (head.last)
            begin
                total_cnt_next  = '0;
                shadow_cnt_next = '0;
                beam_cnt_next   = '0;
                out_valid_next  = 1'b1;
            end
            else
            begin
                total_cnt_next  = total_upd;
                shadow_cnt_next = shadow_upd;
                beam_cnt_next   = beam_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= zvpd_pkg::ZS_ROAD;
            exit_stamp_reg <= '0;
            total_cnt_reg  <= '0;
            shadow_cnt_reg <= '0;
            beam_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (frame_end)
            begin
                state_reg      <= state_next;
                exit_stamp_reg <= exit_stamp_next;
            end
            total_cnt_reg  <= total_cnt_next;
            shadow_cnt_reg <= shadow_cnt_next;
            beam_cnt_reg   <= beam_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            event_reg      <= event_next;
            total_res_reg  <= total_w;
            shadow_res_reg <= CMP_W'(shadow_upd);
            beam_res_reg   <= CMP_W'(beam_upd);
        end
    end

    // The zone state only moves at a frame end, which also reloads the result.
    assign out_valid     = out_valid_reg;
    assign event_res     = event_reg;
    assign zone_state    = state_reg;
    assign changed_count = total_res_reg[zvpd_pkg::CFG_W-1:0];
    assign shadow_count  = shadow_res_reg[zvpd_pkg::CFG_W-1:0];
    assign beam_count    = beam_res_reg[zvpd_pkg::CFG_W-1:0];

    `ZVPD_ASSERT_SAME(a_enter_means_car,
        out_valid_reg && (event_reg == zvpd_pkg::EV_ENTER), state_reg == zvpd_pkg::ZS_CAR)
    `ZVPD_ASSERT_SAME(a_leave_means_no_car,
        out_valid_reg && (event_reg == zvpd_pkg::EV_LEAVE), state_reg != zvpd_pkg::ZS_CAR)
    `ZVPD_ASSERT_SAME(a_sub_counts_bounded, 1'b1,
        (shadow_cnt_reg <= total_cnt_reg) && (beam_cnt_reg <= total_cnt_reg))
    `ZVPD_ASSERT_NEXT(a_frame_end_clears, frame_end,
        (total_cnt_reg == '0) && (shadow_cnt_reg == '0) && (beam_cnt_reg == '0))

endmodule

`default_nettype wire
